>>> rtl/scfb_pkg.sv
// scfb_pkg: types, widths and constants shared by the spectral comb filter bin unit
// covers transaction payloads, register codes and the cordic arctangent table
// no dependencies
package scfb_pkg;

   localparam int PITCH_W  = 16;
   localparam int RANGE_W  = 17;
   localparam int COUNT_W  = 13;
   localparam int INDEX_W  = 12;
   localparam int MAG_W    = 16;
   localparam int PHASE_W  = 16;
   localparam int OMAG_W   = 17;
   localparam int NUM_W    = INDEX_W + RANGE_W;
   localparam int QUO_W    = 32;
   localparam int ANG_W    = 32;
   localparam int NXY_W    = 36;
   localparam int VEC_W    = 38;
   localparam int ROT_LANES = 2;
   localparam int CORDIC_STEPS = 16;
   localparam int ADDR_W   = 4;
   localparam int DATA_W   = 32;

   localparam logic [1:0] REG_PITCH = 2'd0;
   localparam logic [1:0] REG_RANGE = 2'd1;
   localparam logic [1:0] REG_COUNT = 2'd2;

   localparam logic [PITCH_W-1:0] PITCH_RESET = 16'd0;
   localparam logic [RANGE_W-1:0] RANGE_RESET = 17'd22050;
   localparam logic [COUNT_W-1:0] COUNT_RESET = 13'd512;

   localparam logic signed [ANG_W-1:0] ANG_HALF_PI     = 32'sh4000_0000;
   localparam logic signed [ANG_W-1:0] ANG_NEG_HALF_PI = -32'sh4000_0000;
   localparam logic [ANG_W-1:0]        ANG_PI_BIT      = 32'h8000_0000;
   localparam logic signed [ANG_W-1:0] KINV_Q30        = 32'sd652032874;
   localparam logic signed [15:0]      KINV_Q15        = 16'sd19898;
   localparam logic [OMAG_W-1:0]       MAG_MAX         = 17'd131071;

   typedef struct packed {
      logic [INDEX_W-1:0]        bin_index;
      logic [MAG_W-1:0]          magnitude;
      logic signed [PHASE_W-1:0] phase;
   } req_type;

   typedef struct packed {
      logic [OMAG_W-1:0]         out_magnitude;
      logic signed [PHASE_W-1:0] out_phase;
      logic                      applied;
   } rsp_type;

   typedef struct packed {
      logic                      bypass;
      logic [MAG_W-1:0]          magnitude;
      logic signed [PHASE_W-1:0] phase;
   } side_type;

   function automatic logic signed [ANG_W-1:0] atan_value(input logic [3:0] k);
      logic signed [ANG_W-1:0] v;
      case (k)
         4'd0: v = 32'sd536870912;
         4'd1: v = 32'sd316933406;
         4'd2: v = 32'sd167458907;
         4'd3: v = 32'sd85004756;
         4'd4: v = 32'sd42667331;
         4'd5: v = 32'sd21354465;
         4'd6: v = 32'sd10679838;
         4'd7: v = 32'sd5340245;
         4'd8: v = 32'sd2670163;
         4'd9: v = 32'sd1335087;
         4'd10: v = 32'sd667544;
         4'd11: v = 32'sd333772;
         4'd12: v = 32'sd166886;
         4'd13: v = 32'sd83443;
         4'd14: v = 32'sd41722;
         4'd15: v = 32'sd20861;
         default: v = '0;
      endcase
      return v;
   endfunction

endpackage

>>> rtl/scfb_div.sv
// scfb_div: pipelined restoring divider, one quotient bit per stage
// returns the low 32 quotient bits of (num << 32) / den; uses scfb_pkg
module scfb_div #(
   parameter int DEN_W = 29
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           in_valid,
   input  logic [scfb_pkg::NUM_W-1:0]     in_num,
   input  logic [DEN_W-1:0]               den,
   input  scfb_pkg::side_type             in_side,
   output logic                           out_valid,
   output logic [scfb_pkg::QUO_W-1:0]     out_quo,
   output scfb_pkg::side_type             out_side
);

   localparam int STEPS = scfb_pkg::NUM_W + scfb_pkg::QUO_W;

   logic                          valid_ff [STEPS];
   logic [DEN_W-1:0]              rem_ff   [STEPS];
   logic [scfb_pkg::QUO_W-1:0]    quo_ff   [STEPS];
   logic [scfb_pkg::NUM_W-1:0]    num_ff   [STEPS];
   scfb_pkg::side_type            side_ff  [STEPS];

   logic [DEN_W-1:0]              rem_src  [STEPS];
   logic [scfb_pkg::QUO_W-1:0]    quo_src  [STEPS];
   logic [scfb_pkg::NUM_W-1:0]    num_src  [STEPS];
   logic [DEN_W-1:0]              rem_in   [STEPS];
   logic [scfb_pkg::QUO_W-1:0]    quo_in   [STEPS];
   logic [scfb_pkg::NUM_W-1:0]    num_in   [STEPS];

   always_comb begin
      logic [DEN_W:0] trial;
      logic           take;
      rem_src[0] = '0;
      quo_src[0] = '0;
      num_src[0] = in_num;
      for (int s = 1; s < STEPS; s++) begin
         rem_src[s] = rem_ff[s-1];
         quo_src[s] = quo_ff[s-1];
         num_src[s] = num_ff[s-1];
      end
      for (int s = 0; s < STEPS; s++) begin
         trial = {rem_src[s], num_src[s][scfb_pkg::NUM_W-1]};
         take  = trial >= {1'b0, den};
         if (take) begin
            rem_in[s] = DEN_W'(trial - {1'b0, den});
         end else begin
            rem_in[s] = trial[DEN_W-1:0];
         end
         quo_in[s] = {quo_src[s][scfb_pkg::QUO_W-2:0], take};
         num_in[s] = {num_src[s][scfb_pkg::NUM_W-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s < STEPS; s++) valid_ff[s] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s < STEPS; s++) valid_ff[s] <= valid_ff[s-1];
      end
      side_ff[0] <= in_side;
      for (int s = 1; s < STEPS; s++) side_ff[s] <= side_ff[s-1];
      for (int s = 0; s < STEPS; s++) begin
         rem_ff[s] <= rem_in[s];
         quo_ff[s] <= quo_in[s];
         num_ff[s] <= num_in[s];
      end
   end

   assign out_valid = valid_ff[STEPS-1];
   assign out_quo   = quo_ff[STEPS-1];
   assign out_side  = side_ff[STEPS-1];

endmodule

>>> rtl/scfb_rot.sv
// scfb_rot: two-lane pipelined cordic rotation, angle (pi = 2^31) to cos and sin in Q2.30
// one stage per iteration plus quadrant fold and unfold stages; uses scfb_pkg
module scfb_rot (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic signed [scfb_pkg::ANG_W-1:0]   in_angle [scfb_pkg::ROT_LANES],
   input  scfb_pkg::side_type                  in_side,
   output logic                                out_valid,
   output logic signed [scfb_pkg::ANG_W-1:0]   out_cos  [scfb_pkg::ROT_LANES],
   output logic signed [scfb_pkg::ANG_W-1:0]   out_sin  [scfb_pkg::ROT_LANES],
   output scfb_pkg::side_type                  out_side
);

   localparam int STEPS = scfb_pkg::CORDIC_STEPS;
   localparam int LANES = scfb_pkg::ROT_LANES;
   localparam int AW    = scfb_pkg::ANG_W;

   logic                 valid_ff [STEPS+1];
   scfb_pkg::side_type   side_ff  [STEPS+1];
   logic signed [AW-1:0] x_ff     [STEPS+1][LANES];
   logic signed [AW-1:0] y_ff     [STEPS+1][LANES];
   logic signed [AW-1:0] z_ff     [STEPS+1][LANES];
   logic                 flip_ff  [STEPS+1][LANES];
   logic signed [AW-1:0] x_in     [STEPS+1][LANES];
   logic signed [AW-1:0] y_in     [STEPS+1][LANES];
   logic signed [AW-1:0] z_in     [STEPS+1][LANES];
   logic                 flip_in  [STEPS+1][LANES];

   logic                 out_valid_ff;
   scfb_pkg::side_type   out_side_ff;
   logic signed [AW-1:0] cos_ff [LANES];
   logic signed [AW-1:0] sin_ff [LANES];

   always_comb begin
      logic signed [AW-1:0] dx;
      logic signed [AW-1:0] dy;
      for (int l = 0; l < LANES; l++) begin
         x_in[0][l] = scfb_pkg::KINV_Q30;
         y_in[0][l] = '0;
         if (in_angle[l] > scfb_pkg::ANG_HALF_PI ||
             in_angle[l] < scfb_pkg::ANG_NEG_HALF_PI) begin
            z_in[0][l]    = in_angle[l] ^ scfb_pkg::ANG_PI_BIT;
            flip_in[0][l] = 1'b1;
         end else begin
            z_in[0][l]    = in_angle[l];
            flip_in[0][l] = 1'b0;
         end
      end
      for (int k = 0; k < STEPS; k++) begin
         for (int l = 0; l < LANES; l++) begin
            dx = y_ff[k][l] >>> k;
            dy = x_ff[k][l] >>> k;
            flip_in[k+1][l] = flip_ff[k][l];
            if (z_ff[k][l] >= 0) begin
               x_in[k+1][l] = x_ff[k][l] - dx;
               y_in[k+1][l] = y_ff[k][l] + dy;
               z_in[k+1][l] = z_ff[k][l] - scfb_pkg::atan_value(4'(k));
            end else begin
               x_in[k+1][l] = x_ff[k][l] + dx;
               y_in[k+1][l] = y_ff[k][l] - dy;
               z_in[k+1][l] = z_ff[k][l] + scfb_pkg::atan_value(4'(k));
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= STEPS; s++) valid_ff[s] <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s <= STEPS; s++) valid_ff[s] <= valid_ff[s-1];
         out_valid_ff <= valid_ff[STEPS];
      end
      side_ff[0] <= in_side;
      for (int s = 1; s <= STEPS; s++) side_ff[s] <= side_ff[s-1];
      for (int s = 0; s <= STEPS; s++) begin
         for (int l = 0; l < LANES; l++) begin
            x_ff[s][l]    <= x_in[s][l];
            y_ff[s][l]    <= y_in[s][l];
            z_ff[s][l]    <= z_in[s][l];
            flip_ff[s][l] <= flip_in[s][l];
         end
      end
      out_side_ff <= side_ff[STEPS];
      for (int l = 0; l < LANES; l++) begin
         cos_ff[l] <= flip_ff[STEPS][l] ? -x_ff[STEPS][l] : x_ff[STEPS][l];
         sin_ff[l] <= flip_ff[STEPS][l] ? -y_ff[STEPS][l] : y_ff[STEPS][l];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_side  = out_side_ff;
   assign out_cos   = cos_ff;
   assign out_sin   = sin_ff;

endmodule

>>> rtl/scfb_vec.sv
// scfb_vec: pipelined cordic vectoring, (x, y) to scaled length and angle (pi = 2^31)
// one stage for the left half-plane fold, then one stage per iteration; uses scfb_pkg
module scfb_vec (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                in_valid,
   input  logic signed [scfb_pkg::NXY_W-1:0]   in_x,
   input  logic signed [scfb_pkg::NXY_W-1:0]   in_y,
   input  scfb_pkg::side_type                  in_side,
   output logic                                out_valid,
   output logic signed [scfb_pkg::VEC_W-1:0]   out_x,
   output logic signed [scfb_pkg::ANG_W-1:0]   out_z,
   output logic                                out_zero,
   output scfb_pkg::side_type                  out_side
);

   localparam int STEPS = scfb_pkg::CORDIC_STEPS;
   localparam int VW    = scfb_pkg::VEC_W;
   localparam int AW    = scfb_pkg::ANG_W;

   logic                 valid_ff [STEPS+1];
   scfb_pkg::side_type   side_ff  [STEPS+1];
   logic                 zero_ff  [STEPS+1];
   logic signed [VW-1:0] x_ff     [STEPS+1];
   logic signed [VW-1:0] y_ff     [STEPS+1];
   logic signed [AW-1:0] z_ff     [STEPS+1];
   logic signed [VW-1:0] x_in     [STEPS+1];
   logic signed [VW-1:0] y_in     [STEPS+1];
   logic signed [AW-1:0] z_in     [STEPS+1];

   always_comb begin
      logic signed [VW-1:0] dx;
      logic signed [VW-1:0] dy;
      if (in_x < 0) begin
         x_in[0] = -VW'(in_x);
         y_in[0] = -VW'(in_y);
         z_in[0] = AW'(scfb_pkg::ANG_PI_BIT);
      end else begin
         x_in[0] = VW'(in_x);
         y_in[0] = VW'(in_y);
         z_in[0] = '0;
      end
      for (int k = 0; k < STEPS; k++) begin
         dx = y_ff[k] >>> k;
         dy = x_ff[k] >>> k;
         if (y_ff[k] >= 0) begin
            x_in[k+1] = x_ff[k] + dx;
            y_in[k+1] = y_ff[k] - dy;
            z_in[k+1] = z_ff[k] + scfb_pkg::atan_value(4'(k));
         end else begin
            x_in[k+1] = x_ff[k] - dx;
            y_in[k+1] = y_ff[k] + dy;
            z_in[k+1] = z_ff[k] - scfb_pkg::atan_value(4'(k));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int s = 0; s <= STEPS; s++) valid_ff[s] <= 1'b0;
      end else begin
         valid_ff[0] <= in_valid;
         for (int s = 1; s <= STEPS; s++) valid_ff[s] <= valid_ff[s-1];
      end
      side_ff[0] <= in_side;
      zero_ff[0] <= (in_x == '0) && (in_y == '0);
      for (int s = 1; s <= STEPS; s++) begin
         side_ff[s] <= side_ff[s-1];
         zero_ff[s] <= zero_ff[s-1];
      end
      for (int s = 0; s <= STEPS; s++) begin
         x_ff[s] <= x_in[s];
         y_ff[s] <= y_in[s];
         z_ff[s] <= z_in[s];
      end
   end

   assign out_valid = valid_ff[STEPS];
   assign out_x     = x_ff[STEPS];
   assign out_z     = z_ff[STEPS];
   assign out_zero  = zero_ff[STEPS];
   assign out_side  = side_ff[STEPS];

endmodule

>>> rtl/spectral_comb_filter_bin_unit.sv
// spectral_comb_filter_bin_unit: top level of the frequency-domain comb filter for one bin
// depends on scfb_pkg, scfb_div, scfb_rot and scfb_vec
//
// usage:
//   a transaction is accepted at a rising edge with start high and busy low; req_item
//   carries bin_index, magnitude and phase. busy is high only during reset, so one
//   transaction can be accepted every cycle.
//   each result appears on rsp_item for exactly one cycle with rsp_strobe high, in the
//   order of acceptance; the receiver cannot stall, so nothing is ever held back.
//   the divider takes 61 stages, one per quotient bit: 29 bits of index*range plus 32
//   fraction bits; the stage counts do not depend on MAX_BINS. the rest of the path
//   is the entry stage, a 18-stage rotation cordic, a 17-stage vectoring cordic and
//   six multiply/round/output stages.
//   throughput is one transaction per cycle.
//   registers pitch_hz, spectral_range_hz, bin_count sit at byte addresses 0, 4, 8 of
//   the apb port; the user must see that they are written only while no transaction is
//   in flight, as the block itself does not enforce it.
//   reset (synchronous) empties the pipeline and restores register defaults.
module spectral_comb_filter_bin_unit #(
   parameter int MAX_BINS = 4096
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              start,
   output logic                              busy,
   input  scfb_pkg::req_type                 req_item,
   output logic                              rsp_strobe,
   output scfb_pkg::rsp_type                 rsp_item,
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [scfb_pkg::ADDR_W-1:0]       paddr,
   input  logic [scfb_pkg::DATA_W-1:0]       pwdata,
   output logic [scfb_pkg::DATA_W-1:0]       prdata,
   output logic                              pready
);

   localparam int CNT_W = $clog2(MAX_BINS + 1);
   localparam int DEN_W = scfb_pkg::PITCH_W + CNT_W;

   // configuration
   logic [scfb_pkg::PITCH_W-1:0] pitch_ff;
   logic [scfb_pkg::RANGE_W-1:0] range_ff;
   logic [scfb_pkg::COUNT_W-1:0] count_ff;
   logic [1:0]                   reg_sel;
   logic                         csr_write;
   logic [CNT_W-1:0]             eff_count;
   logic [DEN_W-1:0]             den_ff;

   assign reg_sel   = paddr[3:2];
   assign csr_write = psel && penable && pwrite && pready;
   assign pready    = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         pitch_ff <= scfb_pkg::PITCH_RESET;
         range_ff <= scfb_pkg::RANGE_RESET;
         count_ff <= scfb_pkg::COUNT_RESET;
      end else if (csr_write) begin
         case (reg_sel)
            scfb_pkg::REG_PITCH: pitch_ff <= pwdata[scfb_pkg::PITCH_W-1:0];
            scfb_pkg::REG_RANGE: range_ff <= pwdata[scfb_pkg::RANGE_W-1:0];
            scfb_pkg::REG_COUNT: count_ff <= pwdata[scfb_pkg::COUNT_W-1:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (reg_sel)
         scfb_pkg::REG_PITCH: prdata = scfb_pkg::DATA_W'(pitch_ff);
         scfb_pkg::REG_RANGE: prdata = scfb_pkg::DATA_W'(range_ff);
         scfb_pkg::REG_COUNT: prdata = scfb_pkg::DATA_W'(count_ff);
         default:             prdata = '0;
      endcase
   end

   always_comb begin
      if (count_ff == '0) begin
         eff_count = CNT_W'(1);
      end else if (32'(count_ff) > 32'(MAX_BINS)) begin
         eff_count = CNT_W'(MAX_BINS);
      end else begin
         eff_count = CNT_W'(count_ff);
      end
   end

   always_ff @(posedge clock) begin
      den_ff <= DEN_W'(pitch_ff) * DEN_W'(eff_count);
   end

   // entry stage
   logic                          accept;
   logic                          e_valid_ff;
   logic [scfb_pkg::NUM_W-1:0]    e_num_ff;
   scfb_pkg::side_type            e_side_ff;

   assign busy   = reset;
   assign accept = start && !busy;

   always_ff @(posedge clock) begin
      if (reset) e_valid_ff <= 1'b0;
      else       e_valid_ff <= accept;
      e_num_ff            <= scfb_pkg::NUM_W'(req_item.bin_index) *
                             scfb_pkg::NUM_W'(range_ff);
      e_side_ff.bypass    <= (pitch_ff == '0);
      e_side_ff.magnitude <= req_item.magnitude;
      e_side_ff.phase     <= req_item.phase;
   end

   // comb angle
   logic                          d_valid;
   logic [scfb_pkg::QUO_W-1:0]    d_quo;
   scfb_pkg::side_type            d_side;

   scfb_div #(.DEN_W(DEN_W)) u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (e_valid_ff),
      .in_num    (e_num_ff),
      .den       (den_ff),
      .in_side   (e_side_ff),
      .out_valid (d_valid),
      .out_quo   (d_quo),
      .out_side  (d_side)
   );

   // cos and sin of comb angle (lane 0) and of input phase (lane 1)
   logic signed [scfb_pkg::ANG_W-1:0] r_angle [scfb_pkg::ROT_LANES];
   logic signed [scfb_pkg::ANG_W-1:0] r_cos   [scfb_pkg::ROT_LANES];
   logic signed [scfb_pkg::ANG_W-1:0] r_sin   [scfb_pkg::ROT_LANES];
   logic                              r_valid;
   scfb_pkg::side_type                r_side;

   assign r_angle[0] = $signed(d_quo);
   assign r_angle[1] = {d_side.phase, 16'h0000};

   scfb_rot u_rot (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (d_valid),
      .in_angle  (r_angle),
      .in_side   (d_side),
      .out_valid (r_valid),
      .out_cos   (r_cos),
      .out_sin   (r_sin),
      .out_side  (r_side)
   );

   // t1: round to Q1.15
   logic signed [33:0] comb_re_sum;
   logic signed [33:0] comb_im_sum;
   logic signed [32:0] pc_sum;
   logic signed [32:0] ps_sum;
   logic               t1_valid_ff;
   scfb_pkg::side_type t1_side_ff;
   logic signed [17:0] comb_re_ff;
   logic signed [17:0] comb_im_ff;
   logic signed [17:0] pc_ff;
   logic signed [17:0] ps_ff;

   assign comb_re_sum = 34'sd1073741824 + 34'(r_cos[0]) + 34'sd32768;
   assign comb_im_sum = 34'sd1073741824 - 34'(r_sin[0]) + 34'sd32768;
   assign pc_sum      = 33'(r_cos[1]) + 33'sd16384;
   assign ps_sum      = 33'(r_sin[1]) + 33'sd16384;

   // t2: rectangular form
   logic               t2_valid_ff;
   scfb_pkg::side_type t2_side_ff;
   logic signed [34:0] re_ff;
   logic signed [34:0] im_ff;
   logic signed [17:0] t2_comb_re_ff;
   logic signed [17:0] t2_comb_im_ff;
   logic signed [34:0] re_in;
   logic signed [34:0] im_in;

   assign re_in = $signed({1'b0, t1_side_ff.magnitude}) * pc_ff;
   assign im_in = $signed({1'b0, t1_side_ff.magnitude}) * ps_ff;

   // t3: partial products of the complex multiply
   logic               t3_valid_ff;
   scfb_pkg::side_type t3_side_ff;
   logic signed [52:0] prr_ff;
   logic signed [52:0] pii_ff;
   logic signed [52:0] pri_ff;
   logic signed [52:0] pir_ff;
   logic signed [52:0] prr_in;
   logic signed [52:0] pii_in;
   logic signed [52:0] pri_in;
   logic signed [52:0] pir_in;

   assign prr_in = re_ff * t2_comb_re_ff;
   assign pii_in = im_ff * t2_comb_im_ff;
   assign pri_in = re_ff * t2_comb_im_ff;
   assign pir_in = im_ff * t2_comb_re_ff;

   // t4: sum and round to Q15
   logic                              t4_valid_ff;
   scfb_pkg::side_type                t4_side_ff;
   logic signed [scfb_pkg::NXY_W-1:0] nx_ff;
   logic signed [scfb_pkg::NXY_W-1:0] ny_ff;
   logic signed [53:0]                nx_sum;
   logic signed [53:0]                ny_sum;

   assign nx_sum = 54'(prr_ff) - 54'(pii_ff) + 54'sd16384;
   assign ny_sum = 54'(pri_ff) + 54'(pir_ff) + 54'sd16384;

   always_ff @(posedge clock) begin
      if (reset) begin
         t1_valid_ff <= 1'b0;
         t2_valid_ff <= 1'b0;
         t3_valid_ff <= 1'b0;
         t4_valid_ff <= 1'b0;
      end else begin
         t1_valid_ff <= r_valid;
         t2_valid_ff <= t1_valid_ff;
         t3_valid_ff <= t2_valid_ff;
         t4_valid_ff <= t3_valid_ff;
      end
      t1_side_ff    <= r_side;
      comb_re_ff    <= comb_re_sum[33:16];
      comb_im_ff    <= comb_im_sum[33:16];
      pc_ff         <= pc_sum[32:15];
      ps_ff         <= ps_sum[32:15];
      t2_side_ff    <= t1_side_ff;
      re_ff         <= re_in;
      im_ff         <= im_in;
      t2_comb_re_ff <= comb_re_ff;
      t2_comb_im_ff <= comb_im_ff;
      t3_side_ff    <= t2_side_ff;
      prr_ff        <= prr_in;
      pii_ff        <= pii_in;
      pri_ff        <= pri_in;
      pir_ff        <= pir_in;
      t4_side_ff    <= t3_side_ff;
      nx_ff         <= scfb_pkg::NXY_W'(nx_sum >>> 15);
      ny_ff         <= scfb_pkg::NXY_W'(ny_sum >>> 15);
   end

   // back to polar form
   logic                              v_valid;
   logic signed [scfb_pkg::VEC_W-1:0] v_x;
   logic signed [scfb_pkg::ANG_W-1:0] v_z;
   logic                              v_zero;
   scfb_pkg::side_type                v_side;

   scfb_vec u_vec (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (t4_valid_ff),
      .in_x      (nx_ff),
      .in_y      (ny_ff),
      .in_side   (t4_side_ff),
      .out_valid (v_valid),
      .out_x     (v_x),
      .out_z     (v_z),
      .out_zero  (v_zero),
      .out_side  (v_side)
   );

   // t5: gain correction product
   logic                              t5_valid_ff;
   logic                              t5_zero_ff;
   scfb_pkg::side_type                t5_side_ff;
   logic signed [scfb_pkg::ANG_W-1:0] t5_z_ff;
   logic signed [53:0]                lp_ff;
   logic signed [53:0]                lp_in;

   assign lp_in = v_x * scfb_pkg::KINV_Q15;

   always_ff @(posedge clock) begin
      if (reset) t5_valid_ff <= 1'b0;
      else       t5_valid_ff <= v_valid;
      t5_zero_ff <= v_zero;
      t5_side_ff <= v_side;
      t5_z_ff    <= v_z;
      lp_ff      <= lp_in;
   end

   // t6: round, saturate, select bypass
   logic signed [53:0]             len_sum;
   logic signed [53:0]             len_val;
   logic [scfb_pkg::OMAG_W-1:0]    len_sat;
   logic [scfb_pkg::PHASE_W-1:0]   ang_round;
   logic                           rsp_strobe_ff;
   scfb_pkg::rsp_type              rsp_item_ff;
   scfb_pkg::rsp_type              rsp_item_in;

   assign len_sum   = lp_ff + 54'sd536870912;
   assign len_val   = len_sum >>> 30;
   assign ang_round = t5_z_ff[31:16] + {15'd0, t5_z_ff[15]};

   always_comb begin
      if (len_val > 54'sd131071) begin
         len_sat = scfb_pkg::MAG_MAX;
      end else if (len_val < 0) begin
         len_sat = '0;
      end else begin
         len_sat = len_val[scfb_pkg::OMAG_W-1:0];
      end
      if (t5_side_ff.bypass) begin
         rsp_item_in.out_magnitude = {1'b0, t5_side_ff.magnitude};
         rsp_item_in.out_phase     = t5_side_ff.phase;
         rsp_item_in.applied       = 1'b0;
      end else if (t5_zero_ff) begin
         rsp_item_in.out_magnitude = '0;
         rsp_item_in.out_phase     = '0;
         rsp_item_in.applied       = 1'b1;
      end else begin
         rsp_item_in.out_magnitude = len_sat;
         rsp_item_in.out_phase     = $signed(ang_round);
         rsp_item_in.applied       = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) rsp_strobe_ff <= 1'b0;
      else       rsp_strobe_ff <= t5_valid_ff;
      rsp_item_ff <= rsp_item_in;
   end

   assign rsp_strobe = rsp_strobe_ff;
   assign rsp_item   = rsp_item_ff;

`ifndef NO_ASSERTIONS
   a_last_stage: assert property (@(posedge clock) disable iff (reset)
      t5_valid_ff |=> rsp_strobe)
      else $error("result lost between last stage and output register");

   a_bypass_width: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_item.applied |-> rsp_item.out_magnitude[scfb_pkg::OMAG_W-1] == 1'b0)
      else $error("passed-through transaction with magnitude above input range");

   a_zero_vector: assert property (@(posedge clock) disable iff (reset)
      t5_valid_ff && t5_zero_ff && !t5_side_ff.bypass |=>
         rsp_item.out_magnitude == '0 && rsp_item.out_phase == '0)
      else $error("zero vector did not give zero magnitude and phase");
`endif

endmodule
